// File: hw/rtl/gose_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the grid octile successor expander.
// Used by gose_ctrl, gose_dp and grid_octile_successor_expander; no dependencies.
package gose_pkg;

    localparam int COORD_BITS_DEF = 8;
    localparam int N_NBR          = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 9;

    localparam logic [16:0] COST_ORTHO = 17'd65536;
    localparam logic [16:0] COST_DIAG  = 17'd92682;
    localparam logic [14:0] OCT_FACTOR = 15'd27146;
    localparam logic [24:0] EST_MAX    = 25'h1FF_FFFF;

    localparam logic [2:0] K_LAST = 3'(N_NBR - 1);

    // neighbor slots of the orthogonal moves in the emit order
    localparam logic [2:0] K_W = 3'd0;
    localparam logic [2:0] K_E = 3'd1;
    localparam logic [2:0] K_N = 3'd2;
    localparam logic [2:0] K_S = 3'd3;

    localparam logic REQ_MARK   = 1'b0;
    localparam logic REQ_EXPAND = 1'b1;

    // emit order of the neighbors and their column / row offsets
    localparam logic [3:0] DIR_ORDER [N_NBR] = '{4'd3, 4'd5, 4'd1, 4'd7,
                                                 4'd0, 4'd2, 4'd6, 4'd8};
    localparam logic signed [1:0] DIR_DX [N_NBR] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0,
                                                     -2'sd1, 2'sd1, -2'sd1, 2'sd1};
    localparam logic signed [1:0] DIR_DY [N_NBR] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1,
                                                     -2'sd1, -2'sd1, 2'sd1, 2'sd1};

    typedef enum logic [2:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_GOAL_X      = 3'd2,
        CFG_GOAL_Y      = 3'd3,
        CFG_HEUR_MODE   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic       req_type;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
    } t_in_item;

    typedef struct packed {
        logic        move_valid;
        logic [3:0]  move_dir;
        logic [7:0]  next_x;
        logic [7:0]  next_y;
        logic [16:0] step_cost;
        logic [24:0] goal_estimate;
        logic        last_move;
    } t_out_item;

    typedef struct packed {
        logic       clr;
        logic       mark;
        logic       load;
        logic       rd;
        logic [2:0] rd_idx;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic out_free;
        logic last;
    } t_dp_stat;

endpackage

// File: hw/rtl/grid_octile_successor_expander.sv
`timescale 1ns / 1ps
// Eight-connected grid successor expander with octile heuristic. A mark request sets one
// cell of the obstacle bitmap. An expand request gives n results (n is at least 1): it is
// accepted, the eight neighbor bits are read one by one through the single port of the
// bitmap memory, the last bit is captured, then one result per cycle goes into the output
// register while the sink keeps up.
// Results come in direction order 3,5,1,7,0,2,6,8. After reset the bitmap is swept clear,
// one cell per cycle, over all 2^(2*COORD_BITS) cells (65536 at the default); input ready
// stays low during the sweep while configuration writes are taken. Depends on gose_pkg,
// gose_ctrl and gose_dp.
module grid_octile_successor_expander #(
    parameter int COORD_BITS = gose_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  gose_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output gose_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gose_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gose_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    gose_pkg::t_dp_cmd  w_cmd;
    gose_pkg::t_dp_stat w_stat;

    // registers take a transfer in any cycle
    assign o_cfg_ready = 1'b1;

    gose_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    gose_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/gose_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the successor expander: clearing pass, neighbor reads, result emission.
// Depends on gose_pkg; drives gose_dp through t_dp_cmd and reads t_dp_stat.
module gose_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    output logic               o_in_ready,
    output gose_pkg::t_dp_cmd  o_cmd,
    input  gose_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic [2:0] r_k;
    logic       r_in_ready;
    logic       w_acc;

    assign w_acc      = i_in_valid & r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_cmd.mark = w_acc & (i_req_type == gose_pkg::REQ_MARK);
                o_cmd.load = w_acc & (i_req_type == gose_pkg::REQ_EXPAND);
            end
            S_READ: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_idx = r_k;
            end
            S_DRAIN: o_cmd = '0;
            S_EMIT:  o_cmd.emit = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_k        <= '0;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clr_done) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state    <= S_READ;
                        r_k        <= '0;
                        r_in_ready <= 1'b0;
                    end
                end
                S_READ: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == gose_pkg::K_LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_EMIT;
                S_EMIT: begin
                    // leave once the final result of this expansion is loaded
                    if (i_stat.out_free && i_stat.last) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/gose_dp.sv
`timescale 1ns / 1ps
// Datapath: obstacle bitmap memory, configuration registers, neighbor legality,
// cost and octile heuristic, output register. Depends on gose_pkg.
module gose_dp #(
    parameter int COORD_BITS = gose_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gose_pkg::t_dp_cmd                   i_cmd,
    output gose_pkg::t_dp_stat                  o_stat,
    input  gose_pkg::t_in_item                  i_in_data,
    input  logic                                i_cfg_we,
    input  logic [gose_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gose_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output gose_pkg::t_out_item                 o_out_data
);

    localparam int AW = 2 * COORD_BITS;
    localparam longint unsigned DEPTH = 64'd1 << AW;
    localparam logic [7:0]  L_MASK = (COORD_BITS >= 8) ? 8'hFF : 8'((1 << COORD_BITS) - 1);
    localparam logic [16:0] L_CMAX = 17'((1 << COORD_BITS) - 1);

    logic r_mem [0:DEPTH-1];

    logic [8:0]    r_width;
    logic [8:0]    r_height;
    logic [7:0]    r_goal_x;
    logic [7:0]    r_goal_y;
    logic          r_mode;

    logic [AW-1:0] r_clr_addr;
    logic [7:0]    r_x;
    logic [7:0]    r_y;
    logic          r_rd_q;
    logic          r_rd_vld;
    logic [2:0]    r_rd_idx;
    logic [7:0]    r_blk;
    logic [7:0]    r_done;
    logic          r_out_vld;
    gose_pkg::t_out_item r_out;

    logic signed [9:0] w_nbx [gose_pkg::N_NBR];
    logic signed [9:0] w_nby [gose_pkg::N_NBR];
    logic [7:0]    w_inb;
    logic [7:0]    w_legal;
    logic [7:0]    w_rem;
    logic [2:0]    w_pick;
    logic          w_found;
    logic          w_last;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_mark_addr;
    logic [8:0]    w_px;
    logic [8:0]    w_py;
    logic [8:0]    w_gx;
    logic [8:0]    w_gy;
    logic [8:0]    w_dxa;
    logic [8:0]    w_dya;
    logic [8:0]    w_mx;
    logic [8:0]    w_mn;
    logic [23:0]   w_prod;
    logic [25:0]   w_sum;
    logic [24:0]   w_est;
    logic          w_diag;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_mode   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (gose_pkg::t_cfg_idx'(i_cfg_index))
                gose_pkg::CFG_GRID_WIDTH:  r_width  <= i_cfg_data;
                gose_pkg::CFG_GRID_HEIGHT: r_height <= i_cfg_data;
                gose_pkg::CFG_GOAL_X:      r_goal_x <= i_cfg_data[7:0];
                gose_pkg::CFG_GOAL_Y:      r_goal_y <= i_cfg_data[7:0];
                gose_pkg::CFG_HEUR_MODE:   r_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // neighbor coordinates and bounds
    always_comb begin
        for (int k = 0; k < gose_pkg::N_NBR; k++) begin
            w_nbx[k] = $signed({2'b00, r_x}) + {{8{gose_pkg::DIR_DX[k][1]}}, gose_pkg::DIR_DX[k]};
            w_nby[k] = $signed({2'b00, r_y}) + {{8{gose_pkg::DIR_DY[k][1]}}, gose_pkg::DIR_DY[k]};
            w_inb[k] = !w_nbx[k][9] && !w_nby[k][9]
                    && (17'(w_nbx[k][8:0]) < 17'(r_width))
                    && (17'(w_nbx[k][8:0]) <= L_CMAX)
                    && (17'(w_nby[k][8:0]) < 17'(r_height))
                    && (17'(w_nby[k][8:0]) <= L_CMAX);
        end
    end

    assign w_rd_addr   = {COORD_BITS'(w_nby[i_cmd.rd_idx][8:0]),
                          COORD_BITS'(w_nbx[i_cmd.rd_idx][8:0])};
    assign w_mark_addr = {COORD_BITS'(i_in_data.cell_y & L_MASK),
                          COORD_BITS'(i_in_data.cell_x & L_MASK)};

    // single-port bitmap: clear, mark and neighbor reads never overlap
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.mark) begin
            r_mem[w_mark_addr] <= 1'b1;
        end else if (i_cmd.rd) begin
            r_rd_q <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.rd_idx;
        if (r_rd_vld) begin
            r_blk[r_rd_idx] <= r_rd_q;
        end
        if (i_cmd.load) begin
            r_x    <= i_in_data.cell_x & L_MASK;
            r_y    <= i_in_data.cell_y & L_MASK;
            r_done <= '0;
        end else if (i_cmd.emit && w_found) begin
            r_done[w_pick] <= 1'b1;
        end
    end

    // legality: diagonals also need both side cells free
    always_comb begin
        logic       diag;
        logic [2:0] kh;
        logic [2:0] kv;
        for (int k = 0; k < gose_pkg::N_NBR; k++) begin
            diag = (gose_pkg::DIR_DX[k] != 2'sd0) && (gose_pkg::DIR_DY[k] != 2'sd0);
            kh   = gose_pkg::DIR_DX[k][1] ? gose_pkg::K_W : gose_pkg::K_E;
            kv   = gose_pkg::DIR_DY[k][1] ? gose_pkg::K_N : gose_pkg::K_S;
            w_legal[k] = w_inb[k] && !r_blk[k] && (!diag || (!r_blk[kh] && !r_blk[kv]));
        end
    end

    assign w_rem   = w_legal & ~r_done;
    assign w_found = |w_rem;

    always_comb begin
        w_pick = '0;
        for (int k = gose_pkg::N_NBR - 1; k >= 0; k--) begin
            if (w_rem[k]) begin
                w_pick = 3'(k);
            end
        end
    end

    assign w_last = ((w_rem & ~(8'b1 << w_pick)) == 8'b0);

    // octile heuristic from the picked neighbor
    assign w_px   = w_nbx[w_pick][8:0];
    assign w_py   = w_nby[w_pick][8:0];
    assign w_gx   = {1'b0, r_goal_x & L_MASK};
    assign w_gy   = {1'b0, r_goal_y & L_MASK};
    assign w_dxa  = (w_px >= w_gx) ? (w_px - w_gx) : (w_gx - w_px);
    assign w_dya  = (w_py >= w_gy) ? (w_py - w_gy) : (w_gy - w_py);
    assign w_mx   = (w_dxa > w_dya) ? w_dxa : w_dya;
    assign w_mn   = (w_dxa > w_dya) ? w_dya : w_dxa;
    assign w_prod = 24'(w_mn) * 24'(gose_pkg::OCT_FACTOR);
    assign w_sum  = {1'b0, w_mx, 16'h0000} + 26'(w_prod);
    assign w_est  = !r_mode ? 25'd0
                  : (w_sum > 26'(gose_pkg::EST_MAX)) ? gose_pkg::EST_MAX : w_sum[24:0];
    assign w_diag = (gose_pkg::DIR_DX[w_pick] != 2'sd0) && (gose_pkg::DIR_DY[w_pick] != 2'sd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (w_found) begin
                r_out.move_valid    <= 1'b1;
                r_out.move_dir      <= gose_pkg::DIR_ORDER[w_pick];
                r_out.next_x        <= w_px[7:0];
                r_out.next_y        <= w_py[7:0];
                r_out.step_cost     <= w_diag ? gose_pkg::COST_DIAG : gose_pkg::COST_ORTHO;
                r_out.goal_estimate <= w_est;
                r_out.last_move     <= w_last;
            end else begin
                r_out.move_valid    <= 1'b0;
                r_out.move_dir      <= '0;
                r_out.next_x        <= '0;
                r_out.next_y        <= '0;
                r_out.step_cost     <= '0;
                r_out.goal_estimate <= '0;
                r_out.last_move     <= 1'b1;
            end
        end
    end

    assign o_stat.clr_done = (r_clr_addr == '1);
    assign o_stat.out_free = !r_out_vld || i_out_ready;
    assign o_stat.last     = w_last;
    assign o_out_valid     = r_out_vld;
    assign o_out_data      = r_out;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_octile_successor_expander: a directed pass over the special
// cases, then random phases of mark and expand requests. Depends on gose_pkg and the RTL.
module tb;

    localparam int QUIET_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 16;
    // neighbor scan order of an expansion
    localparam logic [3:0] SCAN_ORDER [8] = '{4'd3, 4'd5, 4'd1, 4'd7,
                                             4'd0, 4'd2, 4'd6, 4'd8};

    typedef struct packed {
        gose_pkg::t_cfg_idx idx;
        logic [8:0]         val;
    } t_reg_write;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    gose_pkg::t_in_item  req_data = '0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    gose_pkg::t_cfg_idx  cfg_idx = gose_pkg::CFG_GRID_WIDTH;
    logic [8:0]          cfg_val = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_cfg_ready;
    gose_pkg::t_out_item out_data;

    gose_pkg::t_in_item  requests [$];
    t_reg_write          reg_writes [$];
    gose_pkg::t_out_item successors [$];
    int         reqs_sent = 0;
    int         reqs_taken = 0;
    int         writes_sent = 0;
    int         writes_taken = 0;
    int         errors = 0;
    int         quiet = 0;
    logic       steady = 1'b0;

    // shadow of the block's state
    bit         obstacle [65536];
    logic [8:0] grid_w = 9'd256;
    logic [8:0] grid_h = 9'd256;
    logic [7:0] goal_col = 8'd0;
    logic [7:0] goal_row = 8'd0;
    logic       octile_on = 1'b1;

    grid_octile_successor_expander u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (req_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_val)
    );

    always #6 clk = ~clk;

    task automatic expand_or_mark(input gose_pkg::t_in_item req);
        gose_pkg::t_out_item res;
        int         k, wc, hc, nx, ny, dx, dy, n;
        logic [3:0] d;
        longint     ax, ay, hi, lo, est;
        n = 0;
        if (req.req_type == gose_pkg::REQ_MARK) begin
            obstacle[{req.cell_y, req.cell_x}] = 1'b1;
            return;
        end
        wc = (grid_w > 9'd256) ? 256 : int'(grid_w);
        hc = (grid_h > 9'd256) ? 256 : int'(grid_h);
        for (k = 0; k < 8; k++) begin
            d = SCAN_ORDER[k];
            dx = int'(d % 3) - 1;
            dy = int'(d / 3) - 1;
            nx = int'(req.cell_x) + dx;
            ny = int'(req.cell_y) + dy;
            if (nx < 0 || nx >= wc || ny < 0 || ny >= hc)
                continue;
            if (obstacle[{8'(ny), 8'(nx)}])
                continue;
            // no corner cutting past a blocked orthogonal cell
            if (dx != 0 && dy != 0 && (obstacle[{req.cell_y, 8'(nx)}] ||
                                       obstacle[{8'(ny), req.cell_x}]))
                continue;
            res = '0;
            res.move_valid = 1'b1;
            res.move_dir = d;
            res.next_x = 8'(nx);
            res.next_y = 8'(ny);
            res.step_cost = (dx != 0 && dy != 0) ? gose_pkg::COST_DIAG : gose_pkg::COST_ORTHO;
            if (octile_on) begin
                ax = (nx > goal_col) ? nx - goal_col : goal_col - nx;
                ay = (ny > goal_row) ? ny - goal_row : goal_row - ny;
                hi = (ax > ay) ? ax : ay;
                lo = (ax > ay) ? ay : ax;
                est = hi * 65536 + lo * 27146;
                res.goal_estimate = (est > 33554431) ? gose_pkg::EST_MAX : 25'(est);
            end
            successors.push_back(res);
            n++;
        end
        if (n == 0) begin
            res = '0;
            res.last_move = 1'b1;
            successors.push_back(res);
        end else begin
            successors[successors.size() - 1].last_move = 1'b1;
        end
    endtask

    task automatic check_field(input string fname, input logic [24:0] want, got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    task automatic issue(input logic kind, input logic [7:0] x, y);
        requests.push_back(gose_pkg::t_in_item'{req_type: kind, cell_x: x, cell_y: y});
        reqs_sent++;
    endtask

    task automatic set_grid(input logic [8:0] w, h, gx, gy, input logic mode);
        reg_writes.push_back(t_reg_write'{gose_pkg::CFG_GRID_WIDTH, w});
        reg_writes.push_back(t_reg_write'{gose_pkg::CFG_GRID_HEIGHT, h});
        reg_writes.push_back(t_reg_write'{gose_pkg::CFG_GOAL_X, gx});
        reg_writes.push_back(t_reg_write'{gose_pkg::CFG_GOAL_Y, gy});
        reg_writes.push_back(t_reg_write'{gose_pkg::CFG_HEUR_MODE, {8'd0, mode}});
        writes_sent += 5;
        // hold requests back until the registers are written
        while (writes_taken != writes_sent)
            @(negedge clk);
    endtask

    // hold until every transfer is done and no result is pending, then let a mark settle
    task automatic drain();
        while (reqs_taken != reqs_sent || writes_taken != writes_sent || successors.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // request channel
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expand_or_mark(req_data);
                reqs_taken++;
            end
            if (!in_valid || o_in_ready) begin
                if (requests.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
                    in_valid <= 1'b1;
                    req_data <= requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // register write channel
    always @(posedge clk) begin
        t_reg_write wr;
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_idx)
                    gose_pkg::CFG_GRID_WIDTH:  grid_w = cfg_val;
                    gose_pkg::CFG_GRID_HEIGHT: grid_h = cfg_val;
                    gose_pkg::CFG_GOAL_X:      goal_col = cfg_val[7:0];
                    gose_pkg::CFG_GOAL_Y:      goal_row = cfg_val[7:0];
                    gose_pkg::CFG_HEUR_MODE:   octile_on = cfg_val[0];
                    default: ;
                endcase
                writes_taken++;
            end
            if (!cfg_valid || o_cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    wr = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_idx <= wr.idx;
                    cfg_val <= wr.val;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result channel
    always @(posedge clk) begin
        gose_pkg::t_out_item want;
        out_ready <= steady || ($urandom_range(99) >= 13);
        if (rst_n && o_out_valid && out_ready) begin
            if (successors.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected none, actual %h",
                         $time, out_data);
            end else begin
                want = successors.pop_front();
                check_field("move_valid", 25'(want.move_valid), 25'(out_data.move_valid));
                check_field("move_dir", 25'(want.move_dir), 25'(out_data.move_dir));
                check_field("next_x", 25'(want.next_x), 25'(out_data.next_x));
                check_field("next_y", 25'(want.next_y), 25'(out_data.next_y));
                check_field("step_cost", 25'(want.step_cost), 25'(out_data.step_cost));
                check_field("goal_estimate", want.goal_estimate, out_data.goal_estimate);
                check_field("last_move", 25'(want.last_move), 25'(out_data.last_move));
            end
        end
    end

    // watchdog: long enough for the bitmap clear after reset
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("grid_octile_successor_expander verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int p, i, gw, gh, span, bx, by;
        logic kind;
        logic [7:0] x, y;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full grid, goal bit 8 masked off
        set_grid(9'd256, 9'd256, 9'h1FF, 9'd0, 1'b1);
        issue(gose_pkg::REQ_EXPAND, 8'd0, 8'd0);
        issue(gose_pkg::REQ_EXPAND, 8'd255, 8'd255);
        issue(gose_pkg::REQ_EXPAND, 8'd128, 8'd128);
        issue(gose_pkg::REQ_MARK, 8'd21, 8'd20);
        issue(gose_pkg::REQ_EXPAND, 8'd20, 8'd20);
        issue(gose_pkg::REQ_EXPAND, 8'd21, 8'd20);
        issue(gose_pkg::REQ_MARK, 8'd85, 8'd170);
        issue(gose_pkg::REQ_EXPAND, 8'd170, 8'd85);
        issue(gose_pkg::REQ_EXPAND, 8'd86, 8'd171);
        issue(gose_pkg::REQ_MARK, 8'd200, 8'd200);
        drain();
        // zero width: nothing in bounds
        set_grid(9'd0, 9'h1FF, 9'd0, 9'd255, 1'b0);
        issue(gose_pkg::REQ_EXPAND, 8'd5, 8'd5);
        drain();
        // small grid: expand outside it, mark outside it
        set_grid(9'd3, 9'd3, 9'd0, 9'd0, 1'b1);
        issue(gose_pkg::REQ_EXPAND, 8'd3, 8'd3);
        issue(gose_pkg::REQ_MARK, 8'd2, 8'd3);
        issue(gose_pkg::REQ_EXPAND, 8'd3, 8'd3);
        issue(gose_pkg::REQ_EXPAND, 8'd1, 8'd1);
        issue(gose_pkg::REQ_EXPAND, 8'd255, 8'd0);
        drain();
        set_grid(9'd1, 9'd1, 9'd0, 9'd0, 1'b1);
        issue(gose_pkg::REQ_EXPAND, 8'd0, 8'd0);
        drain();
        // oversized width clamps to the coordinate range
        set_grid(9'h1FF, 9'd256, 9'd255, 9'd255, 1'b1);
        issue(gose_pkg::REQ_EXPAND, 8'd255, 8'd254);
        issue(gose_pkg::REQ_EXPAND, 8'd199, 8'd200);
        drain();

        for (p = 0; p < 6; p++) begin
            steady = (p == 2);
            case ($urandom_range(9))
                0:       gw = 0;
                1, 2, 3: gw = $urandom_range(1, 12);
                4, 5:    gw = 256;
                6, 7:    gw = $urandom_range(257, 511);
                default: gw = $urandom_range(13, 255);
            endcase
            case ($urandom_range(9))
                0:       gh = 0;
                1, 2, 3: gh = $urandom_range(1, 12);
                4, 5:    gh = 256;
                6, 7:    gh = $urandom_range(257, 511);
                default: gh = $urandom_range(13, 255);
            endcase
            set_grid(9'(gw), 9'(gh), 9'($urandom_range(511)), 9'($urandom_range(511)),
                     1'($urandom_range(1)));
            // work in an 8x8 window so marks crowd the expansions
            if (gw > 256) gw = 256;
            if (gh > 256) gh = 256;
            span = (gw > 8) ? gw - 8 : 0;
            case ($urandom_range(2))
                0:       bx = 0;
                1:       bx = span;
                default: bx = $urandom_range(span);
            endcase
            span = (gh > 8) ? gh - 8 : 0;
            case ($urandom_range(2))
                0:       by = 0;
                1:       by = span;
                default: by = $urandom_range(span);
            endcase
            for (i = 0; i < 14; i++) begin
                kind = ($urandom_range(99) < 35) ? gose_pkg::REQ_MARK : gose_pkg::REQ_EXPAND;
                if ($urandom_range(9) == 0) begin
                    x = 8'($urandom_range(255));
                    y = 8'($urandom_range(255));
                end else begin
                    x = 8'(bx + $urandom_range(7));
                    y = 8'(by + $urandom_range(7));
                end
                issue(kind, x, y);
            end
            drain();
        end

        if (errors == 0) begin
            $display("grid_octile_successor_expander verification clean");
        end else begin
            $display("grid_octile_successor_expander verification failed");
        end
        $finish;
    end

endmodule
